// ===== hdl/aes256_block_decrypt_defines.svh =====
// Assertion macros for the AES-256 decryption block
`ifndef AES256_BLOCK_DECRYPT_DEFINES_SVH
`define AES256_BLOCK_DECRYPT_DEFINES_SVH
`ifndef SYNTHESIS
`define AD_ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define AD_ASSERT_NEXT(label, clk, rstn, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) cond |=> nxt) else $error(msg);
`else
`define AD_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define AD_ASSERT_NEXT(label, clk, rstn, cond, nxt, msg)
`endif
`endif

// ===== hdl/aesd_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for AES-256 decryption
package aesd_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned KeyIdxW   = 4;

  typedef enum logic {
    ACT_LOAD_KEY = 1'b0,
    ACT_DECRYPT  = 1'b1
  } action_t;

  typedef logic [BlockBits-1:0] block_t;

  // Inverse S-box
  localparam logic [7:0] RSBOX_TAB [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Constant-coefficient products needed by InvMixColumns
  function automatic logic [7:0] mul9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a;
  endfunction
  function automatic logic [7:0] mul11(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a2 ^ a;
  endfunction
  function automatic logic [7:0] mul13(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a4 ^ a;
  endfunction
  function automatic logic [7:0] mul14(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    return a8 ^ a4 ^ a2;
  endfunction

  // Byte i of a block, byte 0 most significant
  function automatic logic [7:0] blk_byte(input block_t b, input int unsigned i);
    return b[BlockBits-1-8*i -: 8];
  endfunction

  // InvShiftRows then InvSubBytes
  function automatic block_t shift_sub(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockBits-1-8*(((c+r)%4)*4+r) -: 8] = RSBOX_TAB[blk_byte(s, c*4+r)];
      end
    end
    return t;
  endfunction

  function automatic block_t unmix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = blk_byte(s, c*4); a1 = blk_byte(s, c*4+1);
      a2 = blk_byte(s, c*4+2); a3 = blk_byte(s, c*4+3);
      t[BlockBits-1-8*(c*4)   -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      t[BlockBits-1-8*(c*4+1) -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      t[BlockBits-1-8*(c*4+2) -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      t[BlockBits-1-8*(c*4+3) -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    return t;
  endfunction

endpackage

// ===== hdl/aesd_stream_if.sv =====
// Valid/ready channel carrying one payload
interface aesd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/aesd_round_cell.sv =====
// One round of the inverse cipher as a pipeline cell
module aesd_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            valid_in,
  input  aesd_pkg::block_t state_in,
  input  aesd_pkg::block_t round_key,
  output logic            valid_out,
  output aesd_pkg::block_t state_out
);
  import aesd_pkg::*;

  logic   valid_r;
  block_t state_r, state_nxt, keyed;

  // Shift, substitute, add key, unmix (not in the last round)
  always_comb begin
    keyed     = shift_sub(state_in) ^ round_key;
    state_nxt = LastRound ? keyed : unmix(keyed);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign valid_out = valid_r;
  assign state_out = state_r;
endmodule

// ===== hdl/aes256_block_decrypt.sv =====
// Top level: pipelined AES-256 block decryption with round key store
// One block enters per cycle while the pipeline is not stalled; a block passes
// through the initial key-add register and then one cell per round. The row of
// round cells advances together and stalls only when the result is not taken.
// Key loads use the same input channel and give no result. A key load is held
// off until every block already in the pipeline has been delivered, so each
// block is decrypted with the keys that stood at its own transfer. Load all
// NUM_ROUNDS+1 keys before decrypting.
`include "aes256_block_decrypt_defines.svh"
module aes256_block_decrypt #(
  parameter int NUM_ROUNDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [3:0]  in_key_index,
  input  logic [63:0] in_word_hi,
  input  logic [63:0] in_word_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_plain_hi,
  output logic [63:0] out_plain_lo
);
  import aesd_pkg::*;

  localparam int KeyDepth = NUM_ROUNDS + 1;

  aesd_stream_if #(.payload_t(block_t)) res_ch ();

  block_t key_r [KeyDepth];
  logic   advance, in_xfer, is_dec, pipe_busy, out_stall;
  block_t in_block;

  logic   valid_c [NUM_ROUNDS+1];
  block_t state_c [NUM_ROUNDS+1];
  logic   v0_r;
  block_t s0_r;

  // Any block still in flight, output register included
  always_comb begin
    pipe_busy = 1'b0;
    for (int i = 0; i <= NUM_ROUNDS; i++) begin
      pipe_busy = pipe_busy | valid_c[i];
    end
  end

  assign in_block  = {in_word_hi, in_word_lo};
  assign advance   = !res_ch.valid || res_ch.ready;
  // key loads wait for an empty pipeline
  assign in_ready  = advance && (is_dec || !pipe_busy);
  assign in_xfer   = in_valid && in_ready;
  assign is_dec    = (in_action == ACT_DECRYPT);
  assign out_stall = out_valid && !out_ready;

  // Round key store, each entry at its own fixed tap
  always_ff @(posedge clk) begin
    if (in_xfer && !is_dec && ({28'd0, in_key_index} <= NUM_ROUNDS)) begin
      key_r[in_key_index] <= in_block;
    end
  end

  // Initial AddRoundKey stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= in_xfer && is_dec;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s0_r <= in_block ^ key_r[NUM_ROUNDS];
    end
  end

  assign valid_c[0] = v0_r;
  assign state_c[0] = s0_r;

  // Chain of round cells, key NUM_ROUNDS-1 down to 0
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    aesd_round_cell #(.LastRound(g == NUM_ROUNDS-1)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .valid_in  (valid_c[g]),
      .state_in  (state_c[g]),
      .round_key (key_r[NUM_ROUNDS-1-g]),
      .valid_out (valid_c[g+1]),
      .state_out (state_c[g+1])
    );
  end

  assign res_ch.valid = valid_c[NUM_ROUNDS];
  assign res_ch.data  = state_c[NUM_ROUNDS];
  assign res_ch.ready = out_ready;

  assign out_valid    = res_ch.valid;
  assign out_plain_hi = res_ch.data[127:64];
  assign out_plain_lo = res_ch.data[63:0];

  `AD_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, out_valid && $stable(res_ch.data), "result lost")
  `AD_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid |-> advance, "input stalled with empty output")
  `AD_ASSERT_NEXT(a_load_no_out, clk, rst_n, in_xfer && !is_dec, !v0_r, "key load entered pipeline")
endmodule
